@@ rtl/hgt_pkg.sv @@
package hgt_pkg;

   localparam int unsigned ChanWidth = 32;
   localparam int unsigned GainWidth = 24;
   localparam int unsigned GammaWidth = 16;
   localparam int unsigned PixWidth = 8;
   localparam int unsigned FracBits = 16;
   localparam int unsigned ProdWidth = ChanWidth + GainWidth;
   localparam int unsigned NumLanes = 3;
   // multiply, find msb, normalize, log squarings, scale, split, exp steps, output
   localparam int unsigned LaneDepth = 3 + FracBits + 2 + FracBits + 1;

   localparam logic [GainWidth-1:0] GainReset = 24'd65536;
   localparam logic [GammaWidth-1:0] GammaReset = 16'd7447;

   typedef enum logic [0:0] {
      CSR_EXPOSURE_GAIN = 1'b0,
      CSR_INVERSE_GAMMA = 1'b1
   } csr_index_type;

   typedef logic [31:0] root_arr_type [FracBits];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] val;
      logic [63:0] res;
      logic [63:0] bitv;
      val = v;
      res = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bitv > val) begin
            bitv = bitv >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 64'd0) begin
            if (val >= res + bitv) begin
               val = val - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // 2^(-2^-(k+1)) in Q32
   function automatic root_arr_type build_roots();
      root_arr_type r;
      logic [63:0] c;
      c = isqrt64(64'd1 << 63);
      r[0] = c[31:0];
      for (int k = 1; k < FracBits; k++) begin
         c = isqrt64({c[31:0], 32'd0});
         r[k] = c[31:0];
      end
      return r;
   endfunction

   localparam root_arr_type Roots = build_roots();

endpackage

@@ rtl/hgt_ifc.sv @@
interface hgt_req_if;
   import hgt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] red_linear;
   logic [ChanWidth-1:0] green_linear;
   logic [ChanWidth-1:0] blue_linear;
   logic                 frame_end_in;
   modport source (output valid, red_linear, green_linear, blue_linear, frame_end_in,
                   input ready);
   modport sink (input valid, red_linear, green_linear, blue_linear, frame_end_in,
                 output ready);
endinterface

interface hgt_rsp_if;
   import hgt_pkg::*;
   logic                valid;
   logic                ready;
   logic [PixWidth-1:0] red_display;
   logic [PixWidth-1:0] green_display;
   logic [PixWidth-1:0] blue_display;
   logic [31:0]         packed_argb;
   logic                frame_end_out;
   modport source (output valid, red_display, green_display, blue_display, packed_argb,
                   frame_end_out, input ready);
   modport sink (input valid, red_display, green_display, blue_display, packed_argb,
                 frame_end_out, output ready);
endinterface

interface hgt_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/hgt_lane.sv @@
module hgt_lane (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [hgt_pkg::ChanWidth-1:0]    chan,
   input  logic [hgt_pkg::GainWidth-1:0]    gain,
   input  logic [hgt_pkg::GammaWidth-1:0]   inv_gamma,
   output logic [hgt_pkg::PixWidth-1:0]     pix
);
   import hgt_pkg::*;

   // front: product, msb index, normalized mantissa
   logic [ProdWidth-1:0] prod_ff, prod1_ff;
   logic [5:0]           msb_ff, msb_in;
   logic                 zero1_ff;

   // log squaring chain
   logic [30:0]         m_ff    [FracBits+1];
   logic [FracBits-1:0] frac_ff [FracBits+1];
   logic [5:0]          le_ff   [FracBits+1];
   logic                lz_ff   [FracBits+1];

   logic signed [39:0]  t_ff;
   logic                tz_ff;

   // exp chain
   logic [31:0]         acc_ff  [FracBits+1];
   logic [FracBits-1:0] f_ff    [FracBits+1];
   logic [3:0]          n_ff    [FracBits+1];
   logic                zr_ff   [FracBits+1];
   logic                sat_ff  [FracBits+1];

   logic [PixWidth-1:0] pix_ff;

   always_comb begin
      msb_in = 6'd0;
      for (int k = 0; k < ProdWidth; k++) begin
         if (prod_ff[k]) begin
            msb_in = 6'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= ProdWidth'(chan) * ProdWidth'(gain);
         prod1_ff <= prod_ff;
         msb_ff   <= msb_in;
         zero1_ff <= (prod_ff == '0);
         m_ff[0]    <= 31'(({prod1_ff, 30'd0} >> msb_ff));
         frac_ff[0] <= '0;
         le_ff[0]   <= msb_ff;
         lz_ff[0]   <= zero1_ff;
      end
   end

   for (genvar k = 0; k < FracBits; k++) begin : g_log
      logic [61:0] sq;
      logic [31:0] sh;
      assign sq = 62'(m_ff[k]) * 62'(m_ff[k]);
      assign sh = sq[61:30];
      always_ff @(posedge clock) begin
         if (enable) begin
            m_ff[k+1]    <= sh[31] ? sh[31:1] : sh[30:0];
            frac_ff[k+1] <= {frac_ff[k][FracBits-2:0], sh[31]};
            le_ff[k+1]   <= le_ff[k];
            lz_ff[k+1]   <= lz_ff[k];
         end
      end
   end

   logic [6:0]         e_m32;
   logic signed [22:0] lg;
   logic [39:0]        neg_t;
   logic [9:0]         n_whole;
   assign e_m32   = {1'b0, le_ff[FracBits]} - 7'd32;
   assign lg      = $signed({e_m32, frac_ff[FracBits]});
   assign neg_t   = 40'(-t_ff);
   assign n_whole = neg_t[39:30];

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff  <= 40'(lg) * $signed({24'd0, inv_gamma});
         tz_ff <= lz_ff[FracBits];
         acc_ff[0] <= 32'h8000_0000;
         f_ff[0]   <= neg_t[29:14];
         n_ff[0]   <= n_whole[3:0];
         sat_ff[0] <= !tz_ff && !t_ff[39];
         zr_ff[0]  <= tz_ff || (t_ff[39] && n_whole >= 10'd9);
      end
   end

   for (genvar k = 0; k < FracBits; k++) begin : g_exp
      logic [63:0] pr;
      assign pr = 64'(acc_ff[k]) * 64'(Roots[k]);
      always_ff @(posedge clock) begin
         if (enable) begin
            acc_ff[k+1] <= f_ff[k][FracBits-1-k] ? pr[63:32] : acc_ff[k];
            f_ff[k+1]   <= f_ff[k];
            n_ff[k+1]   <= n_ff[k];
            sat_ff[k+1] <= sat_ff[k];
            zr_ff[k+1]  <= zr_ff[k];
         end
      end
   end

   logic [31:0] acc_sh;
   logic [39:0] scaled;
   logic [8:0]  val;
   assign acc_sh = acc_ff[FracBits] >> n_ff[FracBits];
   assign scaled = 40'(acc_sh) * 40'd255;
   assign val    = scaled[39:31];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (zr_ff[FracBits]) begin
            pix_ff <= '0;
         end else if (sat_ff[FracBits] || val[8]) begin
            pix_ff <= '1;
         end else begin
            pix_ff <= val[7:0];
         end
      end
   end

   assign pix = pix_ff;

endmodule

@@ rtl/hdr_exposure_gamma_tonemap.sv @@
// Each accepted item runs through the lane pipeline to its result
//   (multiply, find msb, normalize, 16 log squaring stages, scale, split, 16 exp2 multiply stages, output).
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active high) empties the pipeline and loads exposure 1.0
//   and inverse gamma 1/2.2.
module hdr_exposure_gamma_tonemap (
   input  logic  clock,
   input  logic  reset,
   hgt_req_if.sink   req_chan,
   hgt_rsp_if.source rsp_chan,
   hgt_csr_if.sink   csr_chan
);
   import hgt_pkg::*;

   logic [GainWidth-1:0]  gain_ff;
   logic [GammaWidth-1:0] igam_ff;
   logic [LaneDepth-1:0]  vld_ff;
   logic [LaneDepth-1:0]  eof_ff;
   logic                  enable;
   logic [PixWidth-1:0]   pix [NumLanes];
   logic [ChanWidth-1:0]  chan [NumLanes];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GainReset;
         igam_ff <= GammaReset;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_EXPOSURE_GAIN: gain_ff <= csr_chan.data;
            CSR_INVERSE_GAMMA: igam_ff <= csr_chan.data[GammaWidth-1:0];
            default: ;
         endcase
      end
   end

   // hold the pipeline while the output item is not taken
   assign enable = !vld_ff[LaneDepth-1] || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[LaneDepth-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         eof_ff <= {eof_ff[LaneDepth-2:0], req_chan.frame_end_in};
      end
   end

   assign chan[0] = req_chan.red_linear;
   assign chan[1] = req_chan.green_linear;
   assign chan[2] = req_chan.blue_linear;

   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      hgt_lane u_lane (
         .clock     (clock),
         .enable    (enable),
         .chan      (chan[i]),
         .gain      (gain_ff),
         .inv_gamma (igam_ff),
         .pix       (pix[i])
      );
   end

   // merge lanes into the result item
   assign rsp_chan.valid         = vld_ff[LaneDepth-1];
   assign rsp_chan.red_display   = pix[0];
   assign rsp_chan.green_display = pix[1];
   assign rsp_chan.blue_display  = pix[2];
   assign rsp_chan.packed_argb   = {8'hFF, pix[0], pix[1], pix[2]};
   assign rsp_chan.frame_end_out = eof_ff[LaneDepth-1];

   a_reset_empty: assert property (@(posedge clock) reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(vld_ff) && $stable(eof_ff))
      else $error("pipeline moved during stall");
   a_stall_cfg: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("item accepted while output stalled");
endmodule
